/* rtl/dbfs_pkg.sv */
// dbfs_pkg: shared constants, types and helpers for the debounced button
// fan speed selector. No dependencies.
`timescale 1ns / 1ps

package dbfs_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int COUNT_WIDTH = 8;
  localparam int CFG_WIDTH   = 8;
  localparam int CMD_WIDTH   = 3;
  localparam int SPEED_WIDTH = 2;
  localparam int DRIVE_WIDTH = 3;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  localparam int IN_DATA_WIDTH  = ((NUM_BUTTONS + CMD_WIDTH + 7) / 8) * 8;
  localparam int OUT_FLD_WIDTH  = SPEED_WIDTH + DRIVE_WIDTH + 2;
  localparam int OUT_DATA_WIDTH = ((OUT_FLD_WIDTH + 7) / 8) * 8;

  localparam logic [CFG_WIDTH-1:0]   DEBOUNCE_RESET = CFG_WIDTH'(35);
  localparam logic [SPEED_WIDTH-1:0] MAX_SPEED      = SPEED_WIDTH'(3);
  localparam logic [SPEED_WIDTH-1:0] SPEED_OFF      = '0;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = '1;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  typedef struct packed {
    logic [SPEED_WIDTH-1:0] speed;
    logic                   applied;
    logic                   rejected;
  } result_t;

  function automatic logic [SPEED_WIDTH-1:0] button_speed(input int idx);
    if (idx > int'(MAX_SPEED)) begin
      return MAX_SPEED;
    end
    return SPEED_WIDTH'(idx);
  endfunction

  function automatic logic [DRIVE_WIDTH-1:0] drive_for(input logic [SPEED_WIDTH-1:0] speed);
    logic [DRIVE_WIDTH-1:0] d;
    d = '1;
    if (speed != SPEED_OFF) begin
      d[speed - SPEED_WIDTH'(1)] = 1'b0;
    end
    return d;
  endfunction

endpackage

/* rtl/dbfs_lane.sv */
// dbfs_lane: debounce lane for one button (raw level, tick counter, stable level).
// Depends on dbfs_pkg.
`timescale 1ns / 1ps

module dbfs_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              tick_en,
  input  logic                              level,
  input  logic [dbfs_pkg::CFG_WIDTH-1:0]    debounce_ticks,
  output logic                              press
);

  logic                             last_raw_r, last_raw_nxt;
  logic                             stable_r, stable_nxt;
  logic [dbfs_pkg::COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                             now_p;
  logic                             qualify;

  assign now_p = ~level;

  always_comb begin
    last_raw_nxt = now_p;
    if (now_p != last_raw_r) begin
      count_nxt = '0;
    end else if (count_r != dbfs_pkg::COUNT_MAX) begin
      count_nxt = count_r + dbfs_pkg::COUNT_WIDTH'(1);
    end else begin
      count_nxt = count_r;
    end
    qualify = (dbfs_pkg::CMP_WIDTH'(count_nxt) >= dbfs_pkg::CMP_WIDTH'(debounce_ticks))
              && (now_p != stable_r);
    stable_nxt = qualify ? now_p : stable_r;
    press      = tick_en && qualify && now_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b0;
      stable_r   <= 1'b0;
      count_r    <= '0;
    end else if (tick_en) begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

/* rtl/dbfs_merge.sv */
// dbfs_merge: combines lane presses (highest index wins) with host commands
// and holds the current fan speed. Depends on dbfs_pkg.
`timescale 1ns / 1ps

module dbfs_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic                               mode,
  input  logic [dbfs_pkg::CMD_WIDTH-1:0]     command_speed,
  input  logic [dbfs_pkg::NUM_BUTTONS-1:0]   press,
  output dbfs_pkg::result_t                  result
);

  logic [dbfs_pkg::SPEED_WIDTH-1:0] speed_r, speed_nxt;
  logic [dbfs_pkg::SPEED_WIDTH-1:0] press_speed;
  logic                             any_press;

  always_comb begin
    press_speed = dbfs_pkg::SPEED_OFF;
    any_press   = 1'b0;
    for (int i = 0; i < dbfs_pkg::NUM_BUTTONS; i++) begin
      if (press[i]) begin
        press_speed = dbfs_pkg::button_speed(i);
        any_press   = 1'b1;
      end
    end
  end

  always_comb begin
    speed_nxt       = speed_r;
    result.applied  = 1'b0;
    result.rejected = 1'b0;
    unique case (mode)
      dbfs_pkg::MODE_COMMAND: begin
        if (command_speed <= dbfs_pkg::CMD_WIDTH'(dbfs_pkg::MAX_SPEED)) begin
          speed_nxt      = dbfs_pkg::SPEED_WIDTH'(command_speed);
          result.applied = 1'b1;
        end else begin
          result.rejected = 1'b1;
        end
      end
      default: begin
        if (any_press) begin
          speed_nxt      = press_speed;
          result.applied = 1'b1;
        end
      end
    endcase
    result.speed = speed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= dbfs_pkg::SPEED_OFF;
    end else if (accept) begin
      speed_r <= speed_nxt;
    end
  end

endmodule

/* rtl/debounced_button_fan_speed_selector_unit.sv */
// debounced_button_fan_speed_selector_unit: top level with button lanes,
// merge stage and output register. Depends on dbfs_pkg, dbfs_lane, dbfs_merge.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tuser: mode; tdata: button_levels, command_speed
//  out_    | out | out_tvalid/out_tready | tdata: speed, drive_lines, applied, rejected
//  cfg_    | in  | cfg_we              | cfg_data: debounce_ticks
//
// One transaction per cycle while the output is not stalled; each result appears the
// cycle after its input is accepted, from the output register.
// Lanes update in parallel on each accepted tick-mode transaction; rate is set by the output register.
// in_tready follows out_tready when a result is held; stalls hold lane, speed and output state.
// Synchronous active-low reset clears lanes, speed and output valid.
`timescale 1ns / 1ps

module debounced_button_fan_speed_selector_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [0] mode
  input  logic                                  in_tuser,
  // [3:0] button_levels, [6:4] command_speed, rest zero
  input  logic [dbfs_pkg::IN_DATA_WIDTH-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [1:0] speed, [4:2] drive_lines, [5] speed_applied, [6] command_rejected
  output logic [dbfs_pkg::OUT_DATA_WIDTH-1:0]   out_tdata,
  input  logic                                  cfg_we,
  input  logic [dbfs_pkg::CFG_WIDTH-1:0]        cfg_data
);

  logic                                   accept;
  logic                                   tick_en;
  logic [dbfs_pkg::NUM_BUTTONS-1:0]       levels;
  logic [dbfs_pkg::CMD_WIDTH-1:0]         cmd;
  logic [dbfs_pkg::NUM_BUTTONS-1:0]       press;
  logic [dbfs_pkg::CFG_WIDTH-1:0]         debounce_r;
  logic                                   out_valid_r, out_valid_nxt;
  logic [dbfs_pkg::OUT_DATA_WIDTH-1:0]    out_data_r, out_data_nxt;
  dbfs_pkg::result_t                      result;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign tick_en   = accept && (in_tuser == dbfs_pkg::MODE_TICK);
  assign levels    = in_tdata[dbfs_pkg::NUM_BUTTONS-1:0];
  assign cmd       = in_tdata[dbfs_pkg::NUM_BUTTONS +: dbfs_pkg::CMD_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= dbfs_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_r <= cfg_data;
    end
  end

  for (genvar g = 0; g < dbfs_pkg::NUM_BUTTONS; g++) begin : g_lane
    dbfs_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .tick_en        (tick_en),
      .level          (levels[g]),
      .debounce_ticks (debounce_r),
      .press          (press[g])
    );
  end

  dbfs_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .mode          (in_tuser),
    .command_speed (cmd),
    .press         (press),
    .result        (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = dbfs_pkg::OUT_DATA_WIDTH'({result.rejected, result.applied,
                                                 dbfs_pkg::drive_for(result.speed),
                                                 result.speed});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
